### src/prxf_pkg.sv
// Shared types, codes and command table for the preamble/XOR frame receiver.
package prxf_pkg;

  localparam int unsigned CMD_TABLE_ENTRIES = 22;
  localparam int unsigned FRAME_LIMIT_BYTES = 256;
  localparam int unsigned QUEUE_DEPTH       = 2;
  localparam int unsigned CMD_TABLE_SIZE    = 32;

  localparam logic [15:0] TIMEOUT_RESET = 16'd5000;

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  localparam logic [7:0] PREAMBLE_FIRST  = 8'h4F;
  localparam logic [7:0] PREAMBLE_SECOND = 8'h6C;
  localparam logic [7:0] REQUEST_CODE    = 8'h4D;
  localparam logic [7:0] LCODE_SHORT     = 8'h02;
  localparam logic [7:0] LCODE_SHORT_FLG = 8'h82;
  localparam logic [7:0] LCODE_ANY       = 8'hFF;
  localparam logic [8:0] HEADER_BYTES    = 9'd6;
  localparam logic [8:0] FRAME_OVERHEAD  = 9'd3;
  localparam logic [8:0] PAYLOAD_START   = 9'd8;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_CHECKSUM     = 3'd1,
    ST_UNKNOWN_CMD  = 3'd2,
    ST_LEN_MISMATCH = 3'd3,
    ST_BAD_LCODE    = 3'd4,
    ST_OVERFLOW     = 3'd5,
    ST_TIMEOUT      = 3'd6
  } status_e;

  localparam logic [7:0] CMD_CODE [CMD_TABLE_SIZE] = '{
    8'h00, 8'h01, 8'h06, 8'h07, 8'h08, 8'h09, 8'h0C, 8'h0D,
    8'h0E, 8'h11, 8'h18, 8'h19, 8'h1A, 8'h1B, 8'h20, 8'h31,
    8'h3A, 8'h3C, 8'h3D, 8'h3F, 8'h40, 8'hF0, 8'h01, 8'h11,
    8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
  };

  localparam logic [7:0] CMD_LCODE [CMD_TABLE_SIZE] = '{
    8'h87, 8'h81, 8'hFF, 8'h82, 8'h82, 8'h81, 8'h02, 8'h02,
    8'h81, 8'h81, 8'h81, 8'h81, 8'h81, 8'h81, 8'h81, 8'h84,
    8'hAC, 8'hAC, 8'hAC, 8'hAC, 8'h81, 8'h01, 8'h01, 8'h01,
    8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
  };

  typedef struct packed {
    logic       operation;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  data_byte;
    logic [7:0]  byte_index;
    logic [2:0]  status;
    logic [7:0]  command;
    logic [4:0]  command_index;
    logic [7:0]  length_code;
    logic [15:0] frame_id;
    logic        is_request;
  } out_item_t;

  typedef struct packed {
    logic        is_verdict;
    logic        check;
    logic        xor_ok;
    status_e     pre_status;
    logic [7:0]  data_byte;
    logic [7:0]  byte_index;
    logic [7:0]  command;
    logic [7:0]  length_code;
    logic [7:0]  frame_length;
    logic [15:0] frame_id;
    logic        is_request;
  } job_t;

  typedef struct packed {
    logic valid;
    job_t job;
  } push_t;

endpackage

### src/prxf_front.sv
// Front end: frame parser, header capture, checksum and timeout tracking.
module prxf_front #(
  parameter int unsigned FrameLimitBytes = prxf_pkg::FRAME_LIMIT_BYTES
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  prxf_pkg::in_item_t in_data_i,
  input  logic               cfg_we_i,
  input  logic [15:0]        cfg_wdata_i,
  output prxf_pkg::push_t    push_o
);

  typedef enum logic [3:0] {
    PH_IDLE = 4'b0001,
    PH_PREA = 4'b0010,
    PH_LEN  = 4'b0100,
    PH_BODY = 4'b1000
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [8:0]  offset_q, offset_d;
  logic [7:0]  flen_q, flen_d;
  logic [7:0]  xor_q, xor_d;
  logic [7:0]  resp_q, resp_d;
  logic [15:0] id_q, id_d;
  logic [7:0]  cmd_q, cmd_d;
  logic [7:0]  clen_q, clen_d;
  logic [15:0] timer_q, timer_d;
  logic [15:0] tmo_cfg_q;

  logic       fire;
  logic [7:0] v;
  logic [8:0] off_next;
  logic       last;
  logic       ovf;

  assign fire     = in_valid_i & in_ready_i;
  assign v        = in_data_i.rx_byte;
  assign off_next = offset_q + 9'd1;
  assign last     = (off_next == ({1'b0, flen_q} + prxf_pkg::FRAME_OVERHEAD));
  assign ovf      = (off_next >= 9'(FrameLimitBytes));

  always_comb begin
    phase_d  = phase_q;
    offset_d = offset_q;
    flen_d   = flen_q;
    xor_d    = xor_q;
    resp_d   = resp_q;
    id_d     = id_q;
    cmd_d    = cmd_q;
    clen_d   = clen_q;
    timer_d  = timer_q;
    push_o   = '0;

    if (fire) begin
      if (in_data_i.operation == prxf_pkg::OP_TICK) begin
        if (phase_q != PH_IDLE) begin
          if (timer_q <= 16'd1) begin
            push_o.valid           = 1'b1;
            push_o.job.is_verdict  = 1'b1;
            push_o.job.pre_status  = prxf_pkg::ST_TIMEOUT;
            phase_d                = PH_IDLE;
          end else begin
            timer_d = timer_q - 16'd1;
          end
        end
      end else begin
        unique case (phase_q)
          PH_IDLE: begin
            if (v == prxf_pkg::PREAMBLE_FIRST) begin
              offset_d = 9'd1;
              xor_d    = prxf_pkg::PREAMBLE_FIRST;
              phase_d  = PH_PREA;
              timer_d  = tmo_cfg_q;
            end
          end
          PH_PREA: begin
            if (v == prxf_pkg::PREAMBLE_SECOND) begin
              offset_d = 9'd2;
              xor_d    = prxf_pkg::PREAMBLE_FIRST ^ prxf_pkg::PREAMBLE_SECOND;
              phase_d  = PH_LEN;
            end else if (v == prxf_pkg::PREAMBLE_FIRST) begin
              offset_d = 9'd1;
              xor_d    = prxf_pkg::PREAMBLE_FIRST;
            end else begin
              offset_d = 9'd0;
              phase_d  = PH_IDLE;
            end
          end
          PH_LEN: begin
            flen_d   = v;
            xor_d    = xor_q ^ v;
            offset_d = 9'd3;
            phase_d  = PH_BODY;
          end
          PH_BODY: begin
            unique case (offset_q)
              9'd3:    resp_d = v;
              9'd4:    id_d   = {id_q[15:8], v};
              9'd5:    id_d   = {v, id_q[7:0]};
              9'd6:    cmd_d  = v;
              9'd7:    clen_d = v;
              default: ;
            endcase
            offset_d = off_next;
            if (last) begin
              push_o.valid          = 1'b1;
              push_o.job.is_verdict = 1'b1;
              push_o.job.check      = 1'b1;
              push_o.job.xor_ok     = (v == xor_q);
              phase_d               = PH_IDLE;
            end else if (ovf) begin
              push_o.valid          = 1'b1;
              push_o.job.is_verdict = 1'b1;
              push_o.job.pre_status = prxf_pkg::ST_OVERFLOW;
              phase_d               = PH_IDLE;
            end else begin
              xor_d = xor_q ^ v;
              if (offset_q >= prxf_pkg::PAYLOAD_START) begin
                push_o.valid          = 1'b1;
                push_o.job.data_byte  = v;
                push_o.job.byte_index = 8'(offset_q - prxf_pkg::PAYLOAD_START);
              end
            end
          end
          default: phase_d = PH_IDLE;
        endcase
      end
    end

    if (push_o.job.is_verdict) begin
      push_o.job.command      = cmd_d;
      push_o.job.length_code  = clen_d;
      push_o.job.frame_length = flen_d;
      push_o.job.frame_id     = id_d;
      push_o.job.is_request   = (resp_d == prxf_pkg::REQUEST_CODE);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      offset_q  <= '0;
      flen_q    <= '0;
      xor_q     <= '0;
      resp_q    <= '0;
      id_q      <= '0;
      cmd_q     <= '0;
      clen_q    <= '0;
      timer_q   <= '0;
      tmo_cfg_q <= prxf_pkg::TIMEOUT_RESET;
    end else begin
      phase_q  <= phase_d;
      offset_q <= offset_d;
      flen_q   <= flen_d;
      xor_q    <= xor_d;
      resp_q   <= resp_d;
      id_q     <= id_d;
      cmd_q    <= cmd_d;
      clen_q   <= clen_d;
      timer_q  <= timer_d;
      if (cfg_we_i) begin
        tmo_cfg_q <= cfg_wdata_i;
      end
    end
  end

endmodule

### src/prxf_queue.sv
// Short FIFO between the parser and the verdict stage.
module prxf_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  prxf_pkg::push_t push_i,
  input  logic            pop_i,
  output logic            head_valid_o,
  output prxf_pkg::job_t  head_o,
  output logic            full_o
);

  localparam int unsigned Depth = prxf_pkg::QUEUE_DEPTH;
  localparam int unsigned PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);

  prxf_pkg::job_t  mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push;
  logic            do_pop;

  assign full_o       = (count_q == CntW'(Depth));
  assign head_valid_o = (count_q != '0);
  assign head_o       = mem_q[rd_ptr_q];
  assign do_push      = push_i.valid & ~full_o;
  assign do_pop       = pop_i & head_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    priority if (do_push && !do_pop) begin
      count_d = count_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CntW'(1);
    end else begin
      count_d = count_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_i.job;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

### src/prxf_back.sv
// Back end: command lookup, verdict checks and the output register.
module prxf_back #(
  parameter int unsigned CmdTableEntries = prxf_pkg::CMD_TABLE_ENTRIES
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                head_valid_i,
  input  prxf_pkg::job_t      head_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output prxf_pkg::out_item_t out_data_o
);

  localparam logic [4:0] NotFound = 5'(CmdTableEntries);

  logic                out_valid_q;
  prxf_pkg::out_item_t out_q, out_d;
  logic                hit;
  logic [4:0]          idx;
  logic [4:0]          found_idx;
  logic [7:0]          tl;
  logic                len_ok;
  logic                lcode_ok;

  assign pop_o       = head_valid_i & (~out_valid_q | out_ready_i);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    hit = 1'b0;
    idx = '0;
    for (int i = int'(CmdTableEntries) - 1; i >= 0; i--) begin
      if (prxf_pkg::CMD_CODE[i] == head_i.command) begin
        hit = 1'b1;
        idx = 5'(i);
      end
    end
  end

  assign found_idx = hit ? idx : NotFound;
  assign tl        = prxf_pkg::CMD_LCODE[idx];
  assign len_ok    = ({1'b0, head_i.frame_length} ==
                      ({2'b00, head_i.length_code[6:0]} + prxf_pkg::HEADER_BYTES));
  assign lcode_ok  = (head_i.length_code == prxf_pkg::LCODE_SHORT) ||
                     (head_i.length_code == prxf_pkg::LCODE_SHORT_FLG) ||
                     (head_i.length_code == tl) ||
                     (head_i.length_code == {1'b0, tl[6:0]}) ||
                     (tl == prxf_pkg::LCODE_ANY);

  always_comb begin
    out_d = '0;
    if (!head_i.is_verdict) begin
      out_d.kind       = prxf_pkg::KIND_PAYLOAD;
      out_d.data_byte  = head_i.data_byte;
      out_d.byte_index = head_i.byte_index;
    end else begin
      out_d.kind        = prxf_pkg::KIND_VERDICT;
      out_d.command     = head_i.command;
      out_d.length_code = head_i.length_code;
      out_d.frame_id    = head_i.frame_id;
      out_d.is_request  = head_i.is_request;
      if (!head_i.check) begin
        out_d.status        = head_i.pre_status;
        out_d.command_index = NotFound;
      end else begin
        out_d.command_index = found_idx;
        priority if (!head_i.xor_ok) begin
          out_d.status = prxf_pkg::ST_CHECKSUM;
        end else if (!hit) begin
          out_d.status = prxf_pkg::ST_UNKNOWN_CMD;
        end else if (!len_ok) begin
          out_d.status = prxf_pkg::ST_LEN_MISMATCH;
        end else if (!lcode_ok) begin
          out_d.status = prxf_pkg::ST_BAD_LCODE;
        end else begin
          out_d.status = prxf_pkg::ST_OK;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop_o) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

endmodule

### src/preamble_xor_frame_receiver.sv
// Top level of the preamble/length/XOR-checksum frame receiver.
//
//   channel  direction  handshake               payload
//   in       input      in_valid_i/in_ready_o   in_data_i   (operation, rx_byte)
//   out      output     out_valid_o/out_ready_i out_data_o  (payload byte or verdict)
//   cfg      input      cfg_we_i, no wait       cfg_wdata_i (timeout_ticks)
//
// One item per cycle while the queue is not full; the parser writes any result into the
// queue at the edge that takes its item, and the verdict stage then loads the output
// register from the queue head once that register is empty or being taken.
// Reset clears the parser, the queue and the output valid; timeout resets to 5000.
// A two-entry queue decouples the parser from the output; in_ready_o drops only
// while the queue is full.
module preamble_xor_frame_receiver #(
  parameter int unsigned CmdTableEntries = prxf_pkg::CMD_TABLE_ENTRIES,
  parameter int unsigned FrameLimitBytes = prxf_pkg::FRAME_LIMIT_BYTES
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  prxf_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output prxf_pkg::out_item_t out_data_o,
  input  logic                cfg_we_i,
  input  logic [15:0]         cfg_wdata_i
);

  prxf_pkg::push_t push;
  prxf_pkg::job_t  head;
  logic            head_valid;
  logic            pop;
  logic            full;

  assign in_ready_o = ~full;

  prxf_front #(
    .FrameLimitBytes(FrameLimitBytes)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_i (in_ready_o),
    .in_data_i  (in_data_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .push_o     (push)
  );

  prxf_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .pop_i       (pop),
    .head_valid_o(head_valid),
    .head_o      (head),
    .full_o      (full)
  );

  prxf_back #(
    .CmdTableEntries(CmdTableEntries)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_valid_i(head_valid),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

### src/prxf_checker.sv
// Port-level checker for the frame receiver and its bind.
module prxf_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_ready_o,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input prxf_pkg::out_item_t out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("output transfer changed while stalled");

  a_payload_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.kind == prxf_pkg::KIND_PAYLOAD |->
      out_data_o.status == 3'd0 && out_data_o.command == 8'd0 &&
      out_data_o.command_index == 5'd0 && out_data_o.length_code == 8'd0 &&
      out_data_o.frame_id == 16'd0 && !out_data_o.is_request)
    else $error("payload transfer carries verdict fields");

  a_verdict_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.kind == prxf_pkg::KIND_VERDICT |->
      out_data_o.data_byte == 8'd0 && out_data_o.byte_index == 8'd0 &&
      out_data_o.status != 3'd7)
    else $error("verdict transfer malformed");

  a_stall_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled with no output transfer pending");

  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o)
    else $error("output valid right after reset");

endmodule

bind preamble_xor_frame_receiver prxf_checker u_prxf_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_ready_o (in_ready_o),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_data_o (out_data_o)
);

### tb/tb_preamble_xor_frame_receiver.sv
// Testbench for the preamble/XOR frame receiver: directed table, random frames, self-checking.
`timescale 1ns / 100ps

module tb_preamble_xor_frame_receiver;

  typedef enum logic [3:0] {
    HUNT   = 4'b0001,
    SYNC   = 4'b0010,
    LENGTH = 4'b0100,
    BODY   = 4'b1000
  } rx_state_e;

  typedef struct {
    bit                  is_cfg;
    logic [15:0]         cfg_val;
    prxf_pkg::in_item_t  item;
    bit                  typed;
    prxf_pkg::out_item_t want;
  } row_t;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid;
  logic                in_ready_o;
  prxf_pkg::in_item_t  in_data;
  logic                out_valid_o;
  logic                out_ready;
  prxf_pkg::out_item_t out_data;
  logic                cfg_we;
  logic [15:0]         cfg_wdata;

  prxf_pkg::out_item_t exp_q[$];
  row_t        dir_rows[$];
  int          mismatch_count = 0;
  int          items_sent = 0;
  int          results_checked = 0;
  int          status_seen[7] = '{default: 0};
  int          hold_requests = 0;
  bit          in_gaps = 1'b1;
  bit          out_gaps = 1'b1;
  int          tick_pct = 4;

  rx_state_e   hunt_state = HUNT;
  logic [8:0]  pos_count = '0;
  logic [7:0]  len_field = '0;
  logic [7:0]  xor_acc = '0;
  logic [7:0]  resp_field = '0;
  logic [15:0] id_field = '0;
  logic [7:0]  cmd_field = '0;
  logic [7:0]  clen_field = '0;
  logic [15:0] ticks_left = '0;
  logic [15:0] timeout_setting = prxf_pkg::TIMEOUT_RESET;

  preamble_xor_frame_receiver dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

  function automatic prxf_pkg::out_item_t mk_payload(logic [7:0] b, logic [7:0] idx);
    prxf_pkg::out_item_t r;
    r = '0;
    r.kind = prxf_pkg::KIND_PAYLOAD;
    r.data_byte = b;
    r.byte_index = idx;
    return r;
  endfunction

  function automatic prxf_pkg::out_item_t mk_verdict(prxf_pkg::status_e st, logic [7:0] cmd,
                                                     logic [4:0] cidx, logic [7:0] lc,
                                                     logic [15:0] id, logic req);
    prxf_pkg::out_item_t r;
    r = '0;
    r.kind = prxf_pkg::KIND_VERDICT;
    r.status = st;
    r.command = cmd;
    r.command_index = cidx;
    r.length_code = lc;
    r.frame_id = id;
    r.is_request = req;
    return r;
  endfunction

  function automatic string to_text(prxf_pkg::out_item_t r);
    return $sformatf("kind %0d data %h pos %0d status %0d cmd %h cidx %0d lcode %h id %h req %0d",
                     r.kind, r.data_byte, r.byte_index, r.status, r.command, r.command_index,
                     r.length_code, r.frame_id, r.is_request);
  endfunction

  function automatic int find_command(logic [7:0] c);
    for (int i = 0; i < prxf_pkg::CMD_TABLE_ENTRIES; i++) begin
      if (prxf_pkg::CMD_CODE[i] == c) return i;
    end
    return prxf_pkg::CMD_TABLE_ENTRIES;
  endfunction

  function automatic void close_frame(prxf_pkg::status_e st, int idx);
    logic [4:0] cidx;
    cidx = idx[4:0];
    exp_q.push_back(mk_verdict(st, cmd_field, cidx, clen_field, id_field,
                               resp_field == prxf_pkg::REQUEST_CODE));
    status_seen[int'(st)]++;
    hunt_state = HUNT;
  endfunction

  function automatic void predict_step(prxf_pkg::in_item_t it);
    logic [7:0] v;
    logic [8:0] pos;
    logic [7:0] tl;
    int         idx;
    v = it.rx_byte;
    if (it.operation == prxf_pkg::OP_TICK) begin
      if (hunt_state == HUNT) return;
      if (ticks_left <= 16'd1) close_frame(prxf_pkg::ST_TIMEOUT, prxf_pkg::CMD_TABLE_ENTRIES);
      else ticks_left = ticks_left - 16'd1;
      return;
    end
    if (hunt_state != BODY) begin
      case (hunt_state)
        HUNT: begin
          if (v == prxf_pkg::PREAMBLE_FIRST) begin
            pos_count = 9'd1;
            xor_acc = prxf_pkg::PREAMBLE_FIRST;
            hunt_state = SYNC;
            ticks_left = timeout_setting;
          end
        end
        SYNC: begin
          if (v == prxf_pkg::PREAMBLE_SECOND) begin
            pos_count = 9'd2;
            xor_acc = prxf_pkg::PREAMBLE_FIRST ^ prxf_pkg::PREAMBLE_SECOND;
            hunt_state = LENGTH;
          end else if (v == prxf_pkg::PREAMBLE_FIRST) begin
            pos_count = 9'd1;
            xor_acc = prxf_pkg::PREAMBLE_FIRST;
          end else begin
            pos_count = 9'd0;
            hunt_state = HUNT;
          end
        end
        default: begin
          len_field = v;
          xor_acc = xor_acc ^ v;
          pos_count = 9'd3;
          hunt_state = BODY;
        end
      endcase
      return;
    end
    pos = pos_count;
    case (pos)
      9'd3: resp_field = v;
      9'd4: id_field[7:0] = v;
      9'd5: id_field[15:8] = v;
      9'd6: cmd_field = v;
      9'd7: clen_field = v;
      default: ;
    endcase
    pos_count = pos + 9'd1;
    if (int'(pos_count) == int'(len_field) + 3) begin
      idx = find_command(cmd_field);
      if (v != xor_acc) begin
        close_frame(prxf_pkg::ST_CHECKSUM, idx);
      end else if (idx >= prxf_pkg::CMD_TABLE_ENTRIES) begin
        close_frame(prxf_pkg::ST_UNKNOWN_CMD, idx);
      end else if (int'(len_field) - int'(clen_field & 8'h7F) != 6) begin
        close_frame(prxf_pkg::ST_LEN_MISMATCH, idx);
      end else begin
        tl = prxf_pkg::CMD_LCODE[idx];
        if (!(clen_field == prxf_pkg::LCODE_SHORT || clen_field == prxf_pkg::LCODE_SHORT_FLG ||
              clen_field == tl || clen_field == (tl & 8'h7F) || tl == prxf_pkg::LCODE_ANY))
          close_frame(prxf_pkg::ST_BAD_LCODE, idx);
        else
          close_frame(prxf_pkg::ST_OK, idx);
      end
      return;
    end
    if (int'(pos_count) >= prxf_pkg::FRAME_LIMIT_BYTES) begin
      close_frame(prxf_pkg::ST_OVERFLOW, prxf_pkg::CMD_TABLE_ENTRIES);
      return;
    end
    xor_acc = xor_acc ^ v;
    if (pos >= prxf_pkg::PAYLOAD_START)
      exp_q.push_back(mk_payload(v, 8'(pos - prxf_pkg::PAYLOAD_START)));
  endfunction

  function automatic void row_in(logic op, logic [7:0] b);
    row_t r;
    r = '{is_cfg: 1'b0, cfg_val: '0, item: '{operation: op, rx_byte: b}, typed: 1'b0, want: '0};
    dir_rows.push_back(r);
  endfunction

  function automatic void row_exp(logic op, logic [7:0] b, prxf_pkg::out_item_t want);
    row_t r;
    r = '{is_cfg: 1'b0, cfg_val: '0, item: '{operation: op, rx_byte: b}, typed: 1'b1, want: want};
    dir_rows.push_back(r);
  endfunction

  function automatic void row_cfg(logic [15:0] v);
    row_t r;
    r = '{is_cfg: 1'b1, cfg_val: v, item: '0, typed: 1'b0, want: '0};
    dir_rows.push_back(r);
  endfunction

  task automatic send_item(prxf_pkg::in_item_t it, bit typed, prxf_pkg::out_item_t want);
    int n_prior;
    while (in_gaps && $urandom_range(99) < 37) begin
      in_valid <= 1'b0;
      @(negedge clk_i);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    n_prior = exp_q.size();
    predict_step(it);
    if (typed) begin
      if (exp_q.size() > n_prior) void'(exp_q.pop_back());
      exp_q.push_back(want);
    end
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_byte(logic [7:0] b);
    prxf_pkg::in_item_t t;
    int                 burst;
    t.operation = prxf_pkg::OP_TICK;
    if ($urandom_range(199) == 0 && tick_pct > 0) burst = $urandom_range(1, 40);
    else burst = ($urandom_range(99) < tick_pct) ? 1 : 0;
    for (int i = 0; i < burst; i++) begin
      t.rx_byte = 8'($urandom_range(255));
      send_item(t, 1'b0, '0);
    end
    t.operation = prxf_pkg::OP_BYTE;
    t.rx_byte = b;
    send_item(t, 1'b0, '0);
  endtask

  task automatic send_noise();
    int         n;
    logic [7:0] b;
    n = $urandom_range(1, 4);
    if ($urandom_range(1) == 0) begin
      b = 8'($urandom_range(255));
      if (b == prxf_pkg::PREAMBLE_SECOND) b = 8'h00;
      send_byte(prxf_pkg::PREAMBLE_FIRST);
      send_byte(b);
    end else begin
      for (int i = 0; i < n; i++) send_byte(8'($urandom_range(255)));
    end
  endtask

  task automatic send_frame(int forced_len);
    logic [7:0] len, resp, idl, idh, cmd, clen, csum, b;
    int         pick, last_pos;
    pick = $urandom_range(0, 24);
    cmd = prxf_pkg::CMD_CODE[pick];
    if ($urandom_range(99) < 15) cmd = 8'($urandom_range(255));
    case ($urandom_range(9))
      0: clen = prxf_pkg::LCODE_SHORT;
      1: clen = prxf_pkg::LCODE_SHORT_FLG;
      2, 3, 4: clen = prxf_pkg::CMD_LCODE[pick];
      5: clen = prxf_pkg::CMD_LCODE[pick] & 8'h7F;
      6, 7: clen = 8'($urandom_range(255));
      default: clen = prxf_pkg::CMD_LCODE[pick] ^ 8'h80;
    endcase
    len = 8'd6 + (clen & 8'h7F);
    if ($urandom_range(99) < 10) len = 8'($urandom_range(1, 20));
    if (forced_len >= 0) len = 8'(forced_len);
    resp = $urandom_range(1) ? prxf_pkg::REQUEST_CODE : 8'($urandom_range(255));
    idl = 8'($urandom_range(255));
    idh = 8'($urandom_range(255));
    send_byte(prxf_pkg::PREAMBLE_FIRST);
    if ($urandom_range(9) == 0) send_byte(prxf_pkg::PREAMBLE_FIRST);
    send_byte(prxf_pkg::PREAMBLE_SECOND);
    send_byte(len);
    csum = prxf_pkg::PREAMBLE_FIRST ^ prxf_pkg::PREAMBLE_SECOND ^ len;
    last_pos = (int'(len) + 2 >= 3 && int'(len) + 2 <= 255) ? int'(len) + 2 : 255;
    for (int p = 3; p <= last_pos; p++) begin
      case (p)
        3: b = resp;
        4: b = idl;
        5: b = idh;
        6: b = cmd;
        7: b = clen;
        default: b = 8'($urandom_range(255));
      endcase
      if (p == int'(len) + 2) begin
        b = csum;
        if ($urandom_range(99) < 12) b = csum ^ 8'($urandom_range(1, 255));
      end
      send_byte(b);
      csum = csum ^ b;
    end
  endtask

  task automatic write_timeout(logic [15:0] v);
    in_valid <= 1'b0;
    while (exp_q.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk_i);
    cfg_we <= 1'b0;
    timeout_setting = v;
    @(negedge clk_i);
  endtask

  initial begin
    int seen;
    int left;
    seen = 0;
    left = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_requests != seen) begin
        seen = hold_requests;
        left = 80;
      end
      if (left > 0) begin
        out_ready <= 1'b0;
        left--;
      end else begin
        out_ready <= !out_gaps || ($urandom_range(99) >= 37);
      end
    end
  end

  always @(posedge clk_i) begin
    prxf_pkg::out_item_t want;
    if (rst_ni && out_valid_o && out_ready) begin
      results_checked++;
      if (exp_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("%0t: unexpected result: %s", $realtime, to_text(out_data));
      end else begin
        want = exp_q.pop_front();
        if (out_data.kind !== want.kind || out_data.data_byte !== want.data_byte ||
            out_data.byte_index !== want.byte_index || out_data.status !== want.status ||
            out_data.command !== want.command ||
            out_data.command_index !== want.command_index ||
            out_data.length_code !== want.length_code ||
            out_data.frame_id !== want.frame_id || out_data.is_request !== want.is_request) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("%0t: result differs", $realtime);
            $display("  expected %s", to_text(want));
            $display("  actual   %s", to_text(out_data));
          end
        end
      end
    end
  end

  initial begin
    logic [15:0] phase_cfg[7];
    int          forced;
    int          start;
    rst_ni = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_wdata = '0;

    row_cfg(16'hFFFF);
    row_in(prxf_pkg::OP_TICK, 8'hFF);
    row_in(prxf_pkg::OP_BYTE, 8'h00);
    row_in(prxf_pkg::OP_BYTE, 8'hFF);
    row_in(prxf_pkg::OP_BYTE, prxf_pkg::PREAMBLE_FIRST);
    row_in(prxf_pkg::OP_BYTE, 8'h00);
    row_in(prxf_pkg::OP_BYTE, prxf_pkg::PREAMBLE_FIRST);
    row_in(prxf_pkg::OP_BYTE, prxf_pkg::PREAMBLE_FIRST);
    row_in(prxf_pkg::OP_BYTE, prxf_pkg::PREAMBLE_SECOND);
    row_in(prxf_pkg::OP_BYTE, 8'h01);
    row_exp(prxf_pkg::OP_BYTE, 8'h22,
            mk_verdict(prxf_pkg::ST_LEN_MISMATCH, 8'h00, 5'd0, 8'h00, 16'h0000, 1'b0));
    row_cfg(16'h0001);
    row_in(prxf_pkg::OP_BYTE, prxf_pkg::PREAMBLE_FIRST);
    row_in(prxf_pkg::OP_BYTE, prxf_pkg::PREAMBLE_SECOND);
    row_exp(prxf_pkg::OP_TICK, 8'h00,
            mk_verdict(prxf_pkg::ST_TIMEOUT, 8'h00, 5'd22, 8'h00, 16'h0000, 1'b0));
    row_in(prxf_pkg::OP_BYTE, prxf_pkg::PREAMBLE_FIRST);
    row_in(prxf_pkg::OP_BYTE, prxf_pkg::PREAMBLE_SECOND);
    row_in(prxf_pkg::OP_BYTE, 8'h08);
    row_in(prxf_pkg::OP_BYTE, prxf_pkg::REQUEST_CODE);
    row_in(prxf_pkg::OP_BYTE, 8'hFF);
    row_in(prxf_pkg::OP_BYTE, 8'hFF);
    row_in(prxf_pkg::OP_BYTE, 8'h0C);
    row_in(prxf_pkg::OP_BYTE, prxf_pkg::LCODE_SHORT);
    row_exp(prxf_pkg::OP_BYTE, 8'h00, mk_payload(8'h00, 8'd0));
    row_exp(prxf_pkg::OP_BYTE, 8'hFF, mk_payload(8'hFF, 8'd1));
    row_exp(prxf_pkg::OP_BYTE, 8'h97,
            mk_verdict(prxf_pkg::ST_OK, 8'h0C, 5'd6, prxf_pkg::LCODE_SHORT, 16'hFFFF, 1'b1));

    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) write_timeout(dir_rows[i].cfg_val);
      else send_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);
    end

    phase_cfg = '{16'hFFFF, 16'h0000, 16'($urandom_range(2, 60)), 16'h0001,
                  prxf_pkg::TIMEOUT_RESET, 16'($urandom_range(100, 65534)), 16'd3};
    for (int ph = 0; ph < 7; ph++) begin
      write_timeout(phase_cfg[ph]);
      in_gaps = (ph != 0);
      out_gaps = (ph != 0);
      case (ph)
        2: forced = 0;
        3: forced = 254;
        4: forced = 255;
        5: forced = 253;
        default: forced = -1;
      endcase
      if (ph == 5) hold_requests++;
      start = items_sent;
      if (forced >= 0) begin
        tick_pct = 0;
        send_frame(forced);
      end
      tick_pct = 4;
      while (items_sent - start < 120) begin
        if ($urandom_range(99) < 8) send_noise();
        else send_frame(-1);
      end
    end

    in_valid <= 1'b0;
    while (exp_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("Run covered %0d input transfers and %0d result transfers over 9 timeout settings",
             items_sent, results_checked);
    $display("Verdicts: ok %0d, checksum %0d, unknown cmd %0d, length %0d, code %0d, %s %0d, %s %0d",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3], status_seen[4],
             "overflow", status_seen[5], "timeout", status_seen[6]);
    if (mismatch_count == 0 && exp_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
